### rtl/core/rebd_pkg.sv
// Package: shared types, codes and constants for the rotary encoder/button decoder
`timescale 1ns / 1ps

package rebd_pkg;

  localparam int CFG_W           = 16;
  localparam int TIMER_WIDTH_DEF = 16;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

  // item kinds
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_ENCODER = 2'd1;
  localparam logic [1:0] KIND_BUTTON  = 2'd2;
  localparam logic [1:0] KIND_ACK     = 2'd3;

  // latched event codes
  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_SHORT = 3'd1;
  localparam logic [2:0] EV_LONG  = 3'd2;
  localparam logic [2:0] EV_CW    = 3'd3;
  localparam logic [2:0] EV_CCW   = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic       trigger_line;
    logic       data_level;
    logic       clock_level;
    logic       button_level;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       event_pending;
    logic       button_held;
    logic       status_led;
  } result_t;

endpackage

### rtl/core/rebd_in_reg.sv
// Input stage: registers one accepted item and hands it on when the next stage takes it
`timescale 1ns / 1ps

module rebd_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rebd_pkg::in_item_t in_item,
  output logic               stage_valid,
  input  logic               stage_take,
  output rebd_pkg::in_item_t stage_item
);
  import rebd_pkg::*;

  logic     valid;
  in_item_t item;

  // room when empty or when the held item leaves this cycle
  assign in_ready    = !valid || stage_take;
  assign stage_valid = valid;
  assign stage_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

### rtl/core/rebd_core.sv
// Decoder state: press timer, latched event, pending flag, LED level and threshold register
`timescale 1ns / 1ps

module rebd_core #(
  parameter int TIMER_WIDTH = rebd_pkg::TIMER_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rebd_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       fire,
  input  rebd_pkg::in_item_t         item,
  output rebd_pkg::result_t          result
);
  import rebd_pkg::*;

  localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  logic [CFG_W-1:0]       long_press_ms;
  logic                   press_active, press_active_next;
  logic [TIMER_WIDTH-1:0] press_ticks, press_ticks_next;
  logic [2:0]             latched_event, latched_event_next;
  logic                   pending_flag, pending_flag_next;
  logic                   led_level, led_level_next;
  logic                   is_long;

  assign is_long = CMP_W'(press_ticks) > CMP_W'(long_press_ms);

  always_comb begin
    press_active_next  = press_active;
    press_ticks_next   = press_ticks;
    latched_event_next = latched_event;
    pending_flag_next  = pending_flag;
    led_level_next     = led_level;
    unique case (item.kind)
      KIND_TICK: begin
        // saturate at all ones
        if (press_active && !(&press_ticks)) begin
          press_ticks_next = press_ticks + 1'b1;
        end
      end
      KIND_ENCODER: begin
        // drop noise: lines must agree
        if (item.data_level == item.clock_level) begin
          pending_flag_next = 1'b1;
          if (item.trigger_line) begin
            latched_event_next = EV_CW;
            led_level_next     = 1'b1;
          end else begin
            latched_event_next = EV_CCW;
            led_level_next     = 1'b0;
          end
        end
      end
      KIND_BUTTON: begin
        if (!item.button_level && !press_active) begin
          press_active_next = 1'b1;
          press_ticks_next  = '0;
        end else if (item.button_level && press_active) begin
          press_active_next = 1'b0;
          pending_flag_next = 1'b1;
          if (is_long) begin
            latched_event_next = EV_LONG;
            led_level_next     = 1'b0;
          end else begin
            latched_event_next = EV_SHORT;
            led_level_next     = 1'b1;
          end
        end else begin
          // abandon a press seen twice; a release with no press does nothing
          press_active_next = 1'b0;
        end
      end
      KIND_ACK: begin
        latched_event_next = EV_NONE;
        pending_flag_next  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign result.event_code    = latched_event_next;
  assign result.event_pending = pending_flag_next;
  assign result.button_held   = press_active_next;
  assign result.status_led    = led_level_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= LONG_PRESS_RESET;
      press_active  <= 1'b0;
      press_ticks   <= '0;
      latched_event <= EV_NONE;
      pending_flag  <= 1'b0;
      led_level     <= 1'b0;
    end else begin
      if (cfg_we) begin
        long_press_ms <= cfg_wdata;
      end
      if (fire) begin
        press_active  <= press_active_next;
        press_ticks   <= press_ticks_next;
        latched_event <= latched_event_next;
        pending_flag  <= pending_flag_next;
        led_level     <= led_level_next;
      end
    end
  end

endmodule

### rtl/core/rebd_out_reg.sv
// Output stage: holds one result item until the consumer takes it
`timescale 1ns / 1ps

module rebd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  output logic              res_ready,
  input  rebd_pkg::result_t res_in,
  output logic              out_valid,
  input  logic              out_ready,
  output rebd_pkg::result_t res_out
);
  import rebd_pkg::*;

  logic    valid;
  result_t res;

  assign res_ready = !valid || out_ready;
  assign out_valid = valid;
  assign res_out   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_ready) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res <= res_in;
    end
  end

endmodule

### rtl/core/rotary_encoder_button_decoder.sv
// Rotary encoder and push-button event decoder with long-press timing (top level)
// Items pass the input register, then their results are held in the result register.
// Throughput: one item per cycle unless out_ready stalls it; each stage holds one item.
// The ready path runs combinationally from out_ready back to in_ready.
// Reset (rst, synchronous): empties both stages, clears press timer, event, pending
// flag and LED, and sets the long-press threshold to 1000 ticks.
`timescale 1ns / 1ps

module rotary_encoder_button_decoder #(
  parameter int TIMER_WIDTH = rebd_pkg::TIMER_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rebd_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 kind,
  input  logic                       trigger_line,
  input  logic                       data_level,
  input  logic                       clock_level,
  input  logic                       button_level,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 event_code,
  output logic                       event_pending,
  output logic                       button_held,
  output logic                       status_led
);
  import rebd_pkg::*;

  in_item_t in_item;
  in_item_t stage_item;
  logic     stage_valid;
  logic     res_ready;
  result_t  res_next;
  result_t  res_out;

  assign in_item.kind         = kind;
  assign in_item.trigger_line = trigger_line;
  assign in_item.data_level   = data_level;
  assign in_item.clock_level  = clock_level;
  assign in_item.button_level = button_level;

  rebd_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .stage_valid (stage_valid),
    .stage_take  (res_ready),
    .stage_item  (stage_item)
  );

  rebd_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (stage_valid && res_ready),
    .item      (stage_item),
    .result    (res_next)
  );

  rebd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (stage_valid),
    .res_ready (res_ready),
    .res_in    (res_next),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign event_code    = res_out.event_code;
  assign event_pending = res_out.event_pending;
  assign button_held   = res_out.button_held;
  assign status_led    = res_out.status_led;

endmodule

### bench/rotary_encoder_button_decoder_tb.sv
// Self-checking testbench for the rotary encoder and push-button event decoder
`timescale 1ns / 1ps

module rotary_encoder_button_decoder_tb;
  import rebd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           kind = KIND_TICK;
  logic                 trigger_line = 1'b0;
  logic                 data_level = 1'b0;
  logic                 clock_level = 1'b0;
  logic                 button_level = 1'b1;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           event_code;
  logic                 event_pending;
  logic                 button_held;
  logic                 status_led;

  rotary_encoder_button_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .trigger_line (trigger_line),
    .data_level   (data_level),
    .clock_level  (clock_level),
    .button_level (button_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_code   (event_code),
    .event_pending(event_pending),
    .button_held  (button_held),
    .status_led   (status_led)
  );

  always #2 clk = ~clk;

  // decoder state as predicted
  logic [CFG_W-1:0]           long_press_cfg = LONG_PRESS_RESET;
  logic                       pred_held = 1'b0;
  logic [TIMER_WIDTH_DEF-1:0] pred_ticks = '0;
  logic [2:0]                 pred_event = EV_NONE;
  logic                       pred_pending = 1'b0;
  logic                       pred_led = 1'b0;

  in_item_t pending_events[$];
  result_t  expected_status[$];
  in_item_t offered_event;

  int send_idle_pct = 34;
  int recv_idle_pct = 67;
  bit hold_request = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int fail_count = 0;
  int stall_cycles = 0;

  function automatic result_t decode_event(in_item_t it);
    result_t r;
    logic       fire;
    logic [2:0] code;
    logic       led;
    fire = 1'b0;
    code = EV_NONE;
    led  = 1'b0;
    case (it.kind)
      KIND_TICK: begin
        if (pred_held && pred_ticks != '1) pred_ticks = pred_ticks + 1'b1;
      end
      KIND_ENCODER: begin
        // lines that disagree are noise: drop the edge
        if (it.data_level == it.clock_level) begin
          fire = 1'b1;
          code = it.trigger_line ? EV_CW : EV_CCW;
          led  = it.trigger_line;
        end
      end
      KIND_BUTTON: begin
        if (!it.button_level && !pred_held) begin
          pred_held  = 1'b1;
          pred_ticks = '0;
        end else if (it.button_level && pred_held) begin
          pred_held = 1'b0;
          fire = 1'b1;
          if (pred_ticks > long_press_cfg) begin
            code = EV_LONG;
            led  = 1'b0;
          end else begin
            code = EV_SHORT;
            led  = 1'b1;
          end
        end else begin
          pred_held = 1'b0;
        end
      end
      default: begin
        pred_event   = EV_NONE;
        pred_pending = 1'b0;
      end
    endcase
    if (fire) begin
      pred_event   = code;
      pred_pending = 1'b1;
      pred_led     = led;
    end
    r.event_code    = pred_event;
    r.event_pending = pred_pending;
    r.button_held   = pred_held;
    r.status_led    = pred_led;
    return r;
  endfunction

  // driver: offer queued items, predict each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_status.push_back(decode_event(offered_event));
      if (!in_valid || in_ready) begin
        if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_event = pending_events.pop_front();
          kind          <= offered_event.kind;
          trigger_line  <= offered_event.trigger_line;
          data_level    <= offered_event.data_level;
          clock_level   <= offered_event.clock_level;
          button_level  <= offered_event.button_level;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result item against the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {event_code, event_pending, button_held, status_led};
        if (expected_status.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: code %0d pending %b held %b led %b",
                     got.event_code, got.event_pending, got.button_held, got.status_led);
          fail_count++;
        end else begin
          want = expected_status.pop_front();
          if (got.event_code !== want.event_code || got.event_pending !== want.event_pending ||
              got.button_held !== want.button_held || got.status_led !== want.status_led) begin
            if (fail_count < 10)
              $display({"mismatch: expected code %0d pending %b held %b led %b, ",
                        "got code %0d pending %b held %b led %b"},
                       want.event_code, want.event_pending, want.button_held, want.status_led,
                       got.event_code, got.event_pending, got.button_held, got.status_led);
            fail_count++;
          end
        end
      end
      // long hold-off so the block fills up and stalls its input
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  task automatic push_event(logic [1:0] k, logic trig, logic dat, logic clkl, logic btn);
    in_item_t it;
    it.kind         = k;
    it.trigger_line = trig;
    it.data_level   = dat;
    it.clock_level  = clkl;
    it.button_level = btn;
    pending_events.push_back(it);
  endtask

  task automatic push_noise();
    push_event(2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic push_rotation();
    logic lvl;
    lvl = 1'($urandom);
    push_event(KIND_ENCODER, 1'($urandom), lvl, lvl, 1'($urandom));
  endtask

  task automatic push_button(logic btn);
    push_event(KIND_BUTTON, 1'($urandom), 1'($urandom), 1'($urandom), btn);
  endtask

  task automatic push_ticks(int n);
    for (int i = 0; i < n; i++)
      push_event(KIND_TICK, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // hold until every queued item has been accepted and answered
  task automatic wait_drained();
    @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_status.size() != 0)
      @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_threshold(logic [CFG_W-1:0] value);
    long_press_cfg = value;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly press / tick / release sequences and clean rotations, some acks and noise
  task automatic add_random_events(int count);
    int added;
    int pick;
    int span;
    int n;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        span = (long_press_cfg < 30) ? 2 * long_press_cfg + 3 : 40;
        n = $urandom_range(0, span);
        push_button(1'b0);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(9) == 0) begin
            if ($urandom_range(1)) push_rotation();
            else push_noise();
          end else begin
            push_ticks(1);
          end
        end
        // now and then press again instead of releasing
        push_button($urandom_range(9) != 0);
        added += n + 2;
      end else if (pick < 65) begin
        push_rotation();
        added++;
      end else if (pick < 75) begin
        push_event(KIND_ACK, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        added++;
      end else begin
        push_noise();
        added++;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] thresholds[4];
    int send_pct[4];
    int recv_pct[4];
    thresholds = '{CFG_W'($urandom_range(1, 30)), '0, '1, CFG_W'($urandom_range(5, 20))};
    send_pct   = '{34, 67, 0, 0};
    recv_pct   = '{67, 34, 0, 0};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset threshold: a short press well under it
    push_button(1'b0);
    push_ticks(1);
    push_button(1'b1);
    wait_drained();

    write_threshold(CFG_W'(3));
    push_ticks(1);
    push_event(KIND_ENCODER, 1'b1, 1'b1, 1'b1, 1'b1);
    push_event(KIND_ENCODER, 1'b0, 1'b0, 1'b0, 1'b0);
    push_event(KIND_ENCODER, 1'b1, 1'b1, 1'b0, 1'b1);
    push_event(KIND_ENCODER, 1'b0, 1'b0, 1'b1, 1'b0);
    push_event(KIND_ACK, 1'b0, 1'b0, 1'b0, 1'b1);
    push_button(1'b1);
    push_button(1'b0);
    push_ticks(3);
    push_button(1'b1);
    push_button(1'b0);
    push_ticks(4);
    push_button(1'b1);
    // press twice: timing is abandoned, release does nothing
    push_button(1'b0);
    push_button(1'b0);
    push_button(1'b1);
    push_event(KIND_ENCODER, 1'b1, 1'b0, 1'b0, 1'b0);
    push_event(KIND_ACK, 1'b1, 1'b1, 1'b1, 1'b0);
    wait_drained();

    write_threshold('0);
    push_button(1'b0);
    push_button(1'b1);
    push_button(1'b0);
    push_ticks(1);
    push_button(1'b1);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      write_threshold(thresholds[p]);
      if (p == 2) hold_request = 1'b1;
      add_random_events(180);
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (expected_status.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
